// ===== hdl/sdspi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_pkg: shared types and constants
// Step codes, operation kinds and result record for the SD SPI sequencer.
// ----------------------------------------------------------------------------
package sdspi_pkg;

    localparam int BLOCK_BYTES   = 512;
    localparam int RESPONSE_POLL = 33;
    localparam int CMD_TRIES     = 1024;
    localparam int OPCOND_TRIES  = 10000;
    localparam int IDLE_BYTES    = 63;
    localparam int TOKEN_WAIT    = 65535;

    localparam logic [2:0] REQ_INIT   = 3'd0;
    localparam logic [2:0] REQ_READ   = 3'd1;
    localparam logic [2:0] REQ_WOPEN  = 3'd2;
    localparam logic [2:0] REQ_WBYTE  = 3'd3;
    localparam logic [2:0] REQ_WFIN   = 3'd4;
    localparam logic [2:0] REQ_CARD   = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ERR    = 2'd1;
    localparam logic [1:0] ST_NOTRDY = 2'd2;

    localparam logic [1:0] AM_BYTE  = 2'd0;
    localparam logic [1:0] AM_BLOCK = 2'd1;
    localparam logic [1:0] AM_NONE  = 2'd2;

    typedef enum logic [5:0] {
        P_IDLE, P_I_IDLE, P_I_C0, P_I_C0P, P_I_C0H, P_I_C8, P_I_C8P, P_I_C8T,
        P_I_AH, P_I_A55, P_I_A55P, P_I_A41, P_I_A41P, P_I_C59, P_I_C59P,
        P_I_C16, P_I_C16P, P_I_C58, P_I_C58P, P_I_OCR, P_I_OCRT, P_I_END,
        P_R_CMD, P_R_TOK, P_R_DATA, P_R_CRC, P_R_END, P_R_ERR,
        P_W_CMD, P_W_CMDP, P_W_TOK, P_W_BYTE,
        P_F_PAD, P_F_POLL, P_F_BUSY, P_F_END,
        P_SERVE
    } step_t;

    typedef enum logic [2:0] {
        OP_FIXED, OP_REPEAT, OP_POLL, OP_TOKEN, OP_DATA, OP_BUSY
    } op_t;

    // one classified item handed from front to back
    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] sector;
        logic [8:0]  offset;
        logic [9:0]  count;
        logic [7:0]  wr_byte;
        logic [7:0]  rx_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  tx_byte;
        logic        tx_valid;
        logic        cs_active;
        logic [63:0] rd_word;
        logic [3:0]  rd_bytes;
        logic        rd_last;
        logic        done_res;
        logic [1:0]  status;
    } res_t;

    localparam int ITEM_W = $bits(item_t);

endpackage

// ===== hdl/sdspi_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_front: input stage and item queue
// Takes unpacked items, drops unused request codes and queues them.
// ----------------------------------------------------------------------------
module sdspi_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sdspi_pkg::item_t     in_item,
    output logic                 q_valid,
    input  logic                 q_ready,
    output sdspi_pkg::item_t     q_item
);

    sdspi_pkg::item_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;
    logic push, pop;

    assign in_ready = (cnt_reg != 3'd4);
    // codes 6 and 7 are swallowed here
    assign push = in_valid && in_ready && (in_item.req_type <= sdspi_pkg::REQ_CARD);
    assign q_valid = (cnt_reg != 3'd0);
    assign pop = q_valid && q_ready;
    assign q_item = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop)  rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'd0, push} - {2'd0, pop};
        end
    end

endmodule

// ===== hdl/sdspi_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdspi_back: sequencer, sector cache and result register
// Carries out one queued item at a time and emits result words.
// ----------------------------------------------------------------------------
module sdspi_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  sdspi_pkg::item_t     q_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output sdspi_pkg::res_t      out_res
);

    // step state
    sdspi_pkg::step_t step_reg, step_next;
    sdspi_pkg::op_t   op_reg, op_next;
    logic [13:0] retry_reg, retry_next;
    logic [5:0]  poll_reg, poll_next;
    logic [9:0]  bidx_reg, bidx_next;
    logic [1:0]  am_reg, am_next;
    logic        hcs_reg, hcs_next;
    logic        wopen_reg, wopen_next;
    logic [9:0]  wleft_reg, wleft_next;
    logic [31:0] csec_reg, csec_next;
    logic        cval_reg, cval_next;
    logic [31:0] rsec_reg, rsec_next;
    logic [8:0]  roff_reg, roff_next;
    logic [9:0]  rcnt_reg, rcnt_next;
    logic        cs_reg, cs_next;
    logic [9:0]  rep_reg, rep_next;
    logic [15:0] wait_reg, wait_next;
    logic [3:0]  flen_reg, flen_next;
    logic [7:0]  fbuf_reg [10];
    logic [7:0]  fbuf_next [10];
    logic [7:0]  repb_reg, repb_next;
    logic [7:0]  wrh_reg, wrh_next;
    logic        tocache_reg, tocache_next;
    logic        c0ok_reg, c0ok_next;
    logic        fti_reg, fti_next;
    logic        wpend_reg, wpend_next;
    logic        plast_reg, plast_next;
    logic [63:0] pword_reg, pword_next;
    logic [3:0]  pn_reg, pn_next;
    // cache serve walker
    logic [9:0]  si_reg, si_next;
    logic        srd_reg, srd_next;
    logic [63:0] sw_reg, sw_next;

    // sector memory
    logic [7:0] store [sdspi_pkg::BLOCK_BYTES];
    logic       st_we;
    logic [8:0] st_wa;
    logic [7:0] st_wd;
    logic [8:0] st_ra;
    logic [7:0] st_rd_reg;

    always_ff @(posedge clk)
    begin
        if (st_we) store[st_wa] <= st_wd;
        st_rd_reg <= store[st_ra];
    end

    // output register
    sdspi_pkg::res_t res_reg, res_next;
    logic ov_reg, ov_next;
    assign out_valid = ov_reg;
    assign out_res   = res_reg;
    logic space;
    assign space = !ov_reg || out_ready;

    // serve mode produces results without input; idle/busy accept items
    logic serving;
    assign serving = (step_reg == sdspi_pkg::P_SERVE);
    assign q_ready = space && !serving;

    logic take;
    assign take = q_valid && q_ready;

    // scratch for the combinational engine
    logic        emitted;
    logic [7:0]  e_tx;
    logic        e_txv;
    logic        e_done;
    logic [1:0]  e_st;
    logic [63:0] e_word;
    logic [3:0]  e_nb;
    logic        e_last;
    logic [7:0]  rx;
    logic [2:0]  rq;
    logic [10:0] offsum;
    logic [31:0] caddr;
    sdspi_pkg::step_t ent;
    logic        do_ent, do_cmp;
    logic [9:0]  pidx;

    function automatic logic [31:0] card_addr(input logic [1:0] am, input logic [31:0] s);
        card_addr = (am == sdspi_pkg::AM_BYTE) ? {s[22:0], 9'd0} : s;
    endfunction

    always_comb
    begin
        step_next = step_reg; op_next = op_reg; retry_next = retry_reg;
        poll_next = poll_reg; bidx_next = bidx_reg; am_next = am_reg;
        hcs_next = hcs_reg; wopen_next = wopen_reg; wleft_next = wleft_reg;
        csec_next = csec_reg; cval_next = cval_reg; rsec_next = rsec_reg;
        roff_next = roff_reg; rcnt_next = rcnt_reg; cs_next = cs_reg;
        rep_next = rep_reg; wait_next = wait_reg; flen_next = flen_reg;
        fbuf_next = fbuf_reg; repb_next = repb_reg; wrh_next = wrh_reg;
        tocache_next = tocache_reg; c0ok_next = c0ok_reg; fti_next = fti_reg;
        wpend_next = wpend_reg; plast_next = plast_reg; pword_next = pword_reg;
        pn_next = pn_reg; si_next = si_reg; srd_next = srd_reg; sw_next = sw_reg;
        res_next = res_reg; ov_next = ov_reg && !out_ready;
        st_we = 1'b0; st_wa = bidx_reg[8:0]; st_wd = q_item.rx_byte;
        // while stalled keep re-reading the byte that is waiting to be packed
        st_ra = roff_reg + si_reg[8:0] - {8'd0, srd_reg};
        emitted = 1'b0; e_tx = '0; e_txv = 1'b0; e_done = 1'b0; e_st = sdspi_pkg::ST_OK;
        e_word = '0; e_nb = '0; e_last = 1'b0;
        rx = q_item.rx_byte; rq = q_item.req_type;
        offsum = {2'd0, q_item.offset} + {1'b0, q_item.count};
        caddr = card_addr(am_reg, rsec_reg);
        ent = sdspi_pkg::P_IDLE; do_ent = 1'b0; do_cmp = 1'b0;
        pidx = '0;

        // ---------------- serve from cache, one byte per cycle while the output has space
        if (serving && space)
        begin
            if (!srd_reg)
            begin
                // prime read of first address
                srd_next = 1'b1;
                si_next  = si_reg + 10'd1;
                st_ra    = roff_reg + si_reg[8:0];
            end
            else
            begin
                st_ra = roff_reg + si_reg[8:0];
                pidx = si_reg - 10'd1;
                sw_next = sw_reg | ({56'd0, st_rd_reg} << {pidx[2:0], 3'd0});
                if (pidx[2:0] == 3'd7 || si_reg == rcnt_reg)
                begin
                    emitted = 1'b1;
                    e_word = sw_reg | ({56'd0, st_rd_reg} << {pidx[2:0], 3'd0});
                    e_nb = {1'b0, pidx[2:0]} + 4'd1;
                    e_last = (si_reg == rcnt_reg);
                    e_done = e_last;
                    sw_next = '0;
                    if (e_last) step_next = sdspi_pkg::P_IDLE;
                end
                si_next = si_reg + 10'd1;
            end
        end
        else if (take)
        begin
            if (rq == sdspi_pkg::REQ_CARD)
            begin
                if (step_reg != sdspi_pkg::P_IDLE)
                begin
                    case (op_reg)
                        sdspi_pkg::OP_FIXED:
                        begin
                            bidx_next = bidx_reg + 10'd1;
                            if ((bidx_reg + 10'd1) < {6'd0, flen_reg})
                            begin
                                emitted = 1'b1; e_txv = 1'b1;
                                e_tx = fbuf_reg[bidx_reg[3:0] + 4'd1];
                            end
                            else do_cmp = 1'b1;
                        end
                        sdspi_pkg::OP_REPEAT:
                        begin
                            if (rep_reg > 10'd1)
                            begin
                                rep_next = rep_reg - 10'd1;
                                emitted = 1'b1; e_txv = 1'b1; e_tx = repb_reg;
                            end
                            else do_cmp = 1'b1;
                        end
                        sdspi_pkg::OP_POLL:
                        begin
                            if (rx != 8'hFF || poll_reg <= 6'd1) do_cmp = 1'b1;
                            else
                            begin
                                poll_next = poll_reg - 6'd1;
                                emitted = 1'b1; e_txv = 1'b1; e_tx = 8'hFF;
                            end
                        end
                        sdspi_pkg::OP_TOKEN:
                        begin
                            if (rx == 8'hFE || wait_reg <= 16'd1) do_cmp = 1'b1;
                            else
                            begin
                                wait_next = wait_reg - 16'd1;
                                emitted = 1'b1; e_txv = 1'b1; e_tx = 8'hFF;
                            end
                        end
                        sdspi_pkg::OP_DATA:
                        begin
                            if (tocache_reg) st_we = 1'b1;
                            else
                            begin
                                pword_next = pword_reg
                                    | ({56'd0, rx} << {pn_reg[2:0], 3'd0});
                                pn_next = pn_reg + 4'd1;
                                if (pn_reg == 4'd7)
                                begin
                                    wpend_next = 1'b1;
                                    plast_next = (bidx_reg == 10'd511);
                                end
                            end
                            bidx_next = bidx_reg + 10'd1;
                            if (bidx_reg != 10'd511)
                            begin
                                emitted = 1'b1; e_txv = 1'b1; e_tx = 8'hFF;
                            end
                            else do_cmp = 1'b1;
                        end
                        default:
                        begin
                            if (rx == 8'hFF) do_cmp = 1'b1;
                            else
                            begin
                                emitted = 1'b1; e_txv = 1'b1; e_tx = 8'hFF;
                            end
                        end
                    endcase
                end
            end
            else if (step_reg == sdspi_pkg::P_IDLE)
            begin
                case (rq)
                    sdspi_pkg::REQ_INIT:
                    begin
                        fti_next = wopen_reg;
                        do_ent = 1'b1;
                        ent = wopen_reg ? sdspi_pkg::P_F_PAD : sdspi_pkg::P_I_IDLE;
                    end
                    sdspi_pkg::REQ_READ:
                    begin
                        if (am_reg == sdspi_pkg::AM_NONE)
                        begin
                            emitted = 1'b1; e_done = 1'b1; e_st = sdspi_pkg::ST_NOTRDY;
                        end
                        else if (wopen_reg || (q_item.count != 10'd512 &&
                                 (q_item.count > 10'd512 || offsum > 11'd512)))
                        begin
                            emitted = 1'b1; e_done = 1'b1; e_st = sdspi_pkg::ST_ERR;
                        end
                        else
                        begin
                            rsec_next = q_item.sector;
                            roff_next = (q_item.count == 10'd512) ? 9'd0 : q_item.offset;
                            rcnt_next = q_item.count;
                            if (cval_reg && csec_reg == q_item.sector)
                            begin
                                if (q_item.count == 10'd0)
                                begin
                                    emitted = 1'b1; e_done = 1'b1;
                                end
                                else
                                begin
                                    step_next = sdspi_pkg::P_SERVE;
                                    si_next = '0; srd_next = 1'b0; sw_next = '0;
                                end
                            end
                            else
                            begin
                                tocache_next = (q_item.count != 10'd512);
                                wpend_next = 1'b0;
                                caddr = card_addr(am_reg, q_item.sector);
                                do_ent = 1'b1; ent = sdspi_pkg::P_R_CMD;
                            end
                        end
                    end
                    sdspi_pkg::REQ_WOPEN:
                    begin
                        if (am_reg == sdspi_pkg::AM_NONE ||
                            (q_item.sector == 32'd0 && !wopen_reg))
                        begin
                            emitted = 1'b1; e_done = 1'b1; e_st = sdspi_pkg::ST_NOTRDY;
                        end
                        else if (q_item.sector == 32'd0)
                        begin
                            fti_next = 1'b0; do_ent = 1'b1; ent = sdspi_pkg::P_F_PAD;
                        end
                        else if (wopen_reg)
                        begin
                            emitted = 1'b1; e_done = 1'b1; e_st = sdspi_pkg::ST_ERR;
                        end
                        else
                        begin
                            rsec_next = q_item.sector;
                            caddr = card_addr(am_reg, q_item.sector);
                            do_ent = 1'b1; ent = sdspi_pkg::P_W_CMD;
                        end
                    end
                    sdspi_pkg::REQ_WBYTE:
                    begin
                        if (am_reg == sdspi_pkg::AM_NONE || !wopen_reg)
                        begin
                            emitted = 1'b1; e_done = 1'b1; e_st = sdspi_pkg::ST_NOTRDY;
                        end
                        else if (wleft_reg == 10'd0)
                        begin
                            emitted = 1'b1; e_done = 1'b1; e_st = sdspi_pkg::ST_ERR;
                        end
                        else
                        begin
                            wleft_next = wleft_reg - 10'd1;
                            wrh_next = q_item.wr_byte;
                            do_ent = 1'b1; ent = sdspi_pkg::P_W_BYTE;
                        end
                    end
                    default:
                    begin
                        if (am_reg == sdspi_pkg::AM_NONE || !wopen_reg)
                        begin
                            emitted = 1'b1; e_done = 1'b1; e_st = sdspi_pkg::ST_NOTRDY;
                        end
                        else
                        begin
                            fti_next = 1'b0; do_ent = 1'b1; ent = sdspi_pkg::P_F_PAD;
                        end
                    end
                endcase
            end
        end

        // ---------------- step completion
        if (do_cmp)
        begin
            case (step_reg)
                sdspi_pkg::P_I_IDLE:
                begin
                    retry_next = 14'(sdspi_pkg::CMD_TRIES); do_ent = 1'b1;
                    ent = sdspi_pkg::P_I_C0;
                end
                sdspi_pkg::P_I_C0P:
                begin
                    c0ok_next = (rx == 8'h01); do_ent = 1'b1; ent = sdspi_pkg::P_I_C0H;
                end
                sdspi_pkg::P_I_C0H:
                begin
                    if (c0ok_reg) begin do_ent = 1'b1; ent = sdspi_pkg::P_I_C8; end
                    else if (retry_reg > 14'd1)
                    begin
                        retry_next = retry_reg - 14'd1; do_ent = 1'b1;
                        ent = sdspi_pkg::P_I_C0;
                    end
                    else begin emitted = 1'b1; e_done = 1'b1; e_st = sdspi_pkg::ST_ERR; end
                end
                sdspi_pkg::P_I_C8P:
                begin
                    hcs_next = !rx[2]; do_ent = 1'b1; ent = sdspi_pkg::P_I_C8T;
                end
                sdspi_pkg::P_I_C8T:
                begin
                    retry_next = 14'(sdspi_pkg::OPCOND_TRIES); do_ent = 1'b1;
                    ent = sdspi_pkg::P_I_AH;
                end
                sdspi_pkg::P_I_A41P, sdspi_pkg::P_I_C59P, sdspi_pkg::P_I_C16P:
                begin
                    if (rx == 8'h00)
                    begin
                        do_ent = 1'b1;
                        if (step_reg == sdspi_pkg::P_I_A41P)
                        begin
                            retry_next = 14'(sdspi_pkg::CMD_TRIES); ent = sdspi_pkg::P_I_C59;
                        end
                        else if (step_reg == sdspi_pkg::P_I_C59P)
                        begin
                            retry_next = 14'(sdspi_pkg::CMD_TRIES); ent = sdspi_pkg::P_I_C16;
                        end
                        else ent = sdspi_pkg::P_I_C58;
                    end
                    else if (retry_reg > 14'd1)
                    begin
                        retry_next = retry_reg - 14'd1; do_ent = 1'b1;
                        if (step_reg == sdspi_pkg::P_I_A41P) ent = sdspi_pkg::P_I_AH;
                        else if (step_reg == sdspi_pkg::P_I_C59P) ent = sdspi_pkg::P_I_C59;
                        else ent = sdspi_pkg::P_I_C16;
                    end
                    else begin emitted = 1'b1; e_done = 1'b1; e_st = sdspi_pkg::ST_ERR; end
                end
                sdspi_pkg::P_I_OCR:
                begin
                    am_next = rx[6] ? sdspi_pkg::AM_BLOCK : sdspi_pkg::AM_BYTE;
                    do_ent = 1'b1; ent = sdspi_pkg::P_I_OCRT;
                end
                sdspi_pkg::P_I_OCRT: begin do_ent = 1'b1; ent = sdspi_pkg::P_I_END; end
                sdspi_pkg::P_I_END, sdspi_pkg::P_W_BYTE:
                begin
                    emitted = 1'b1; e_done = 1'b1;
                end
                sdspi_pkg::P_R_TOK:
                begin
                    do_ent = 1'b1;
                    if (rx == 8'hFE)
                    begin
                        if (tocache_reg)
                        begin
                            csec_next = rsec_reg; cval_next = 1'b1;
                        end
                        ent = sdspi_pkg::P_R_DATA;
                    end
                    else ent = sdspi_pkg::P_R_ERR;
                end
                sdspi_pkg::P_R_DATA: begin do_ent = 1'b1; ent = sdspi_pkg::P_R_CRC; end
                sdspi_pkg::P_R_CRC:  begin do_ent = 1'b1; ent = sdspi_pkg::P_R_END; end
                sdspi_pkg::P_R_END:
                begin
                    if (tocache_reg && rcnt_reg != 10'd0)
                    begin
                        step_next = sdspi_pkg::P_SERVE;
                        si_next = '0; srd_next = 1'b0; sw_next = '0;
                    end
                    else begin emitted = 1'b1; e_done = 1'b1; end
                end
                sdspi_pkg::P_R_ERR:
                begin
                    emitted = 1'b1; e_done = 1'b1; e_st = sdspi_pkg::ST_ERR;
                end
                sdspi_pkg::P_W_CMDP:
                begin
                    if (rx != 8'h00)
                    begin
                        emitted = 1'b1; e_done = 1'b1; e_st = sdspi_pkg::ST_ERR;
                    end
                    else begin do_ent = 1'b1; ent = sdspi_pkg::P_W_TOK; end
                end
                sdspi_pkg::P_W_TOK:
                begin
                    wopen_next = 1'b1; wleft_next = 10'd512;
                    emitted = 1'b1; e_done = 1'b1;
                end
                sdspi_pkg::P_F_PAD:  begin do_ent = 1'b1; ent = sdspi_pkg::P_F_POLL; end
                sdspi_pkg::P_F_POLL: begin do_ent = 1'b1; ent = sdspi_pkg::P_F_BUSY; end
                sdspi_pkg::P_F_BUSY:
                begin
                    wopen_next = 1'b0; wleft_next = '0; do_ent = 1'b1;
                    ent = sdspi_pkg::P_F_END;
                end
                sdspi_pkg::P_F_END:
                begin
                    if (fti_reg)
                    begin
                        fti_next = 1'b0; do_ent = 1'b1; ent = sdspi_pkg::P_I_IDLE;
                    end
                    else begin emitted = 1'b1; e_done = 1'b1; end
                end
                default:
                begin
                    do_ent = 1'b1; ent = sdspi_pkg::step_t'(step_reg + 6'd1);
                end
            endcase
            if (e_done) step_next = sdspi_pkg::P_IDLE;
        end
        else if (emitted && e_done && !serving)
        begin
            step_next = sdspi_pkg::P_IDLE;
        end

        // ---------------- step entry
        if (do_ent)
        begin
            // write pad with nothing left goes straight to the response poll
            if (ent == sdspi_pkg::P_F_PAD && wleft_next == 10'd0)
                ent = sdspi_pkg::P_F_POLL;
            step_next = ent;
            emitted = 1'b1; e_txv = 1'b1; e_tx = 8'hFF;
            bidx_next = '0;
            op_next = sdspi_pkg::OP_FIXED;
            flen_next = 4'd1;
            for (int k = 0; k < 10; k++) fbuf_next[k] = 8'hFF;
            case (ent)
                sdspi_pkg::P_I_IDLE:
                begin
                    cs_next = 1'b0; op_next = sdspi_pkg::OP_REPEAT;
                    repb_next = 8'hFF; rep_next = 10'(sdspi_pkg::IDLE_BYTES + 1);
                end
                sdspi_pkg::P_I_C8T, sdspi_pkg::P_I_OCRT:
                begin
                    op_next = sdspi_pkg::OP_REPEAT; repb_next = 8'hFF;
                    rep_next = (ent == sdspi_pkg::P_I_C8T) ? 10'd4 : 10'd3;
                end
                sdspi_pkg::P_I_C0H, sdspi_pkg::P_I_AH, sdspi_pkg::P_I_END,
                sdspi_pkg::P_R_END, sdspi_pkg::P_R_ERR, sdspi_pkg::P_F_END:
                    cs_next = 1'b0;
                sdspi_pkg::P_I_OCR, sdspi_pkg::P_R_CRC: ;
                sdspi_pkg::P_I_C0, sdspi_pkg::P_I_C8, sdspi_pkg::P_I_C16:
                begin
                    cs_next = 1'b1; flen_next = 4'd6;
                    fbuf_next[0] = (ent == sdspi_pkg::P_I_C0) ? 8'h40 :
                                   (ent == sdspi_pkg::P_I_C8) ? 8'h48 : 8'h50;
                    fbuf_next[1] = 8'h00; fbuf_next[2] = 8'h00;
                    fbuf_next[3] = (ent == sdspi_pkg::P_I_C8) ? 8'h01 :
                                   (ent == sdspi_pkg::P_I_C16) ? 8'h02 : 8'h00;
                    fbuf_next[4] = (ent == sdspi_pkg::P_I_C8) ? 8'hAA : 8'h00;
                    fbuf_next[5] = (ent == sdspi_pkg::P_I_C0) ? 8'h95 :
                                   (ent == sdspi_pkg::P_I_C8) ? 8'h87 : 8'hFF;
                    e_tx = fbuf_next[0];
                end
                sdspi_pkg::P_I_A55, sdspi_pkg::P_I_C59, sdspi_pkg::P_I_C58:
                begin
                    cs_next = 1'b1; flen_next = 4'd8;
                    fbuf_next[2] = (ent == sdspi_pkg::P_I_A55) ? 8'h77 :
                                   (ent == sdspi_pkg::P_I_C59) ? 8'h7B : 8'h7A;
                    fbuf_next[3] = 8'h00; fbuf_next[4] = 8'h00;
                    fbuf_next[5] = 8'h00; fbuf_next[6] = 8'h00;
                end
                sdspi_pkg::P_I_A41:
                begin
                    flen_next = 4'd10;
                    fbuf_next[4] = 8'h69;
                    fbuf_next[5] = hcs_reg ? 8'h40 : 8'h00;
                    fbuf_next[6] = 8'h00; fbuf_next[7] = 8'h00; fbuf_next[8] = 8'h00;
                end
                sdspi_pkg::P_R_CMD:
                begin
                    cs_next = 1'b1; flen_next = 4'd10;
                    fbuf_next[4] = 8'h51;
                    fbuf_next[5] = caddr[31:24]; fbuf_next[6] = caddr[23:16];
                    fbuf_next[7] = caddr[15:8];  fbuf_next[8] = caddr[7:0];
                end
                sdspi_pkg::P_W_CMD:
                begin
                    cs_next = 1'b1; flen_next = 4'd8;
                    fbuf_next[2] = 8'h58;
                    fbuf_next[3] = caddr[31:24]; fbuf_next[4] = caddr[23:16];
                    fbuf_next[5] = caddr[15:8];  fbuf_next[6] = caddr[7:0];
                end
                sdspi_pkg::P_R_TOK:
                begin
                    op_next = sdspi_pkg::OP_TOKEN; wait_next = 16'(sdspi_pkg::TOKEN_WAIT);
                end
                sdspi_pkg::P_R_DATA:
                begin
                    op_next = sdspi_pkg::OP_DATA; pn_next = '0; pword_next = '0;
                end
                sdspi_pkg::P_W_TOK:
                begin
                    flen_next = 4'd2; fbuf_next[1] = 8'hFE;
                end
                sdspi_pkg::P_W_BYTE:
                begin
                    fbuf_next[0] = wrh_next; e_tx = wrh_next;
                end
                sdspi_pkg::P_F_PAD:
                begin
                    op_next = sdspi_pkg::OP_REPEAT; repb_next = 8'h00;
                    rep_next = wleft_next; e_tx = 8'h00;
                end
                sdspi_pkg::P_F_BUSY: op_next = sdspi_pkg::OP_BUSY;
                default:
                begin
                    op_next = sdspi_pkg::OP_POLL;
                    poll_next = 6'(sdspi_pkg::RESPONSE_POLL);
                end
            endcase
        end

        // ---------------- result register load
        if (emitted)
        begin
            ov_next = 1'b1;
            res_next.tx_byte   = e_tx;
            res_next.tx_valid  = e_txv;
            res_next.cs_active = cs_next;
            res_next.rd_word   = e_word;
            res_next.rd_bytes  = e_nb;
            res_next.rd_last   = e_last;
            res_next.done_res  = e_done;
            res_next.status    = e_done ? e_st : sdspi_pkg::ST_OK;
            // a finished bypass word rides on the exchange emitted with it
            if (e_txv && wpend_next)
            begin
                res_next.rd_word  = pword_next;
                res_next.rd_bytes = pn_next;
                res_next.rd_last  = plast_next;
                wpend_next = 1'b0; pword_next = '0; pn_next = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        fbuf_reg <= fbuf_next;
        res_reg  <= res_next;
        rep_reg <= rep_next; wait_reg <= wait_next; flen_reg <= flen_next;
        repb_reg <= repb_next; wrh_reg <= wrh_next; pword_reg <= pword_next;
        pn_reg <= pn_next; si_reg <= si_next; sw_reg <= sw_next;
        rsec_reg <= rsec_next; roff_reg <= roff_next; rcnt_reg <= rcnt_next;
        poll_reg <= poll_next; bidx_reg <= bidx_next; retry_reg <= retry_next;
        wleft_reg <= wleft_next; plast_reg <= plast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= sdspi_pkg::P_IDLE; op_reg <= sdspi_pkg::OP_FIXED;
            am_reg <= sdspi_pkg::AM_NONE; hcs_reg <= 1'b0; wopen_reg <= 1'b0;
            csec_reg <= '1; cval_reg <= 1'b0; cs_reg <= 1'b0;
            tocache_reg <= 1'b0; c0ok_reg <= 1'b0; fti_reg <= 1'b0;
            wpend_reg <= 1'b0; srd_reg <= 1'b0; ov_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next; op_reg <= op_next; am_reg <= am_next;
            hcs_reg <= hcs_next; wopen_reg <= wopen_next; csec_reg <= csec_next;
            cval_reg <= cval_next; cs_reg <= cs_next; tocache_reg <= tocache_next;
            c0ok_reg <= c0ok_next; fti_reg <= fti_next; wpend_reg <= wpend_next;
            srd_reg <= srd_next; ov_reg <= ov_next;
        end
    end

endmodule

// ===== hdl/sd_spi_sector_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sd_spi_sector_controller: SD card SPI-mode host sequencer
// Turns host requests and returned card bytes into exchange words.
// ----------------------------------------------------------------------------
// Each input word is either a host request (init, read, write open, write
// byte, write finish) or a card byte returned by an external shifter. A
// small queue decouples the input from the sequencer. Each word normally
// yields one output word; a read served from the one-sector cache first
// primes the sector memory read and then emits up to 64 packed words at one
// source byte per cycle while the output is not stalled (the single read
// port of the sector memory sets that pace), during which no input is taken.
// Words with unused request codes 6 and 7 are dropped.
module sd_spi_sector_controller
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: req_type[2:0], sector[34:3], offset[43:35], count[53:44],
    //        wr_byte[61:54], rx_byte[69:62], zero pad to 72
    input  logic [71:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: tx_byte[7:0], tx_valid[8], cs_active[9], rd_word[73:10],
    //        rd_bytes[77:74], done_res[78], status[80:79], zero pad to 88
    output logic [87:0]  m_tdata,
    output logic         m_tlast    // rd_last
);

    sdspi_pkg::item_t in_item, q_item;
    sdspi_pkg::res_t  res;
    logic q_valid, q_ready;

    assign in_item.req_type = s_tdata[2:0];
    assign in_item.sector   = s_tdata[34:3];
    assign in_item.offset   = s_tdata[43:35];
    assign in_item.count    = s_tdata[53:44];
    assign in_item.wr_byte  = s_tdata[61:54];
    assign in_item.rx_byte  = s_tdata[69:62];

    sdspi_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    sdspi_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    assign m_tdata = {7'd0, res.status, res.done_res, res.rd_bytes, res.rd_word,
                      res.cs_active, res.tx_valid, res.tx_byte};
    assign m_tlast = res.rd_last;

endmodule

// ===== tb/tb_sd_spi_sector_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sd_spi_sector_controller: self-checking bench for the SD SPI sequencer
// Drives host requests and card replies, predicts every exchange word and
// compares it with the block output under several handshake stall mixes.
// ----------------------------------------------------------------------------
import sdspi_pkg::*;

// Tracks the sequencer state and holds the exchange words still to come.
class spi_seq_tracker;
    step_t       step;
    op_t         op;
    int          retry_left, poll_left, byte_idx, wleft, rep_left, wait_left, flen;
    logic [1:0]  am;
    bit          hcs, wopen, cvalid, cs, to_cache, c0_ok, fin_init, wpend, plast;
    bit [31:0]   csec, rsec;
    int          roff, rcnt, pn;
    bit [7:0]    store[BLOCK_BYTES];
    bit [7:0]    fbuf[10];
    bit [7:0]    rep_byte, wr_hold;
    bit [63:0]   pword;
    res_t        exchange_q[$];
    int          bad, shown;
    // card behavior knobs
    bit          silent, no_token;

    function new();
        step = P_IDLE; op = OP_FIXED; am = AM_NONE; csec = '1;
    endfunction

    function void put(bit [7:0] tx, bit txv, bit [63:0] w, bit [3:0] nb, bit last,
                      bit dn, logic [1:0] st);
        res_t r;
        r.tx_byte = tx; r.tx_valid = txv; r.cs_active = cs; r.rd_word = w;
        r.rd_bytes = nb; r.rd_last = last; r.done_res = dn; r.status = st;
        exchange_q.push_back(r);
    endfunction

    function void send_byte(bit [7:0] tx);
        if (wpend) begin
            put(tx, 1, pword, pn, plast, 0, ST_OK);
            wpend = 0; pword = 0; pn = 0;
        end
        else
            put(tx, 1, 0, 0, 0, 0, ST_OK);
    endfunction

    function void done_with(logic [1:0] st);
        step = P_IDLE;
        put(0, 0, 0, 0, 0, 1, st);
    endfunction

    function void frame(int lead, bit [7:0] cmd, bit [31:0] arg, bit [7:0] crc);
        int n;
        n = 0;
        for (int k = 0; k < lead; k++) fbuf[n++] = 8'hFF;
        fbuf[n++] = cmd;
        fbuf[n++] = arg[31:24]; fbuf[n++] = arg[23:16];
        fbuf[n++] = arg[15:8];  fbuf[n++] = arg[7:0];
        fbuf[n++] = crc;
        flen = n;
    endfunction

    function void go_fixed();
        op = OP_FIXED; byte_idx = 0; send_byte(fbuf[0]);
    endfunction

    function void go_repeat(bit [7:0] b, int n);
        op = OP_REPEAT; rep_byte = b; rep_left = n; send_byte(b);
    endfunction

    function bit [31:0] card_addr();
        return (am == AM_BYTE) ? rsec * BLOCK_BYTES : rsec;
    endfunction

    function void go_step(step_t p);
        step = p;
        case (p)
            P_I_IDLE: begin cs = 0; go_repeat(8'hFF, IDLE_BYTES + 1); end
            P_I_C0:   begin cs = 1; frame(0, 8'h40, 0, 8'h95); go_fixed(); end
            P_I_C8:   begin cs = 1; frame(0, 8'h48, 32'h1AA, 8'h87); go_fixed(); end
            P_I_C8T:  go_repeat(8'hFF, 4);
            P_I_C0H, P_I_AH, P_I_END, P_R_END, P_R_ERR, P_F_END:
            begin
                cs = 0; fbuf[0] = 8'hFF; flen = 1; go_fixed();
            end
            P_I_A55:  begin cs = 1; frame(2, 8'h77, 0, 8'hFF); go_fixed(); end
            P_I_A41:  begin frame(4, 8'h69, hcs ? 32'h4000_0000 : 0, 8'hFF); go_fixed(); end
            P_I_C59:  begin cs = 1; frame(2, 8'h7B, 0, 8'hFF); go_fixed(); end
            P_I_C16:  begin cs = 1; frame(0, 8'h50, BLOCK_BYTES, 8'hFF); go_fixed(); end
            P_I_C58:  begin cs = 1; frame(2, 8'h7A, 0, 8'hFF); go_fixed(); end
            P_I_OCR, P_R_CRC: begin fbuf[0] = 8'hFF; flen = 1; go_fixed(); end
            P_I_OCRT: go_repeat(8'hFF, 3);
            P_R_CMD:  begin cs = 1; frame(4, 8'h51, card_addr(), 8'hFF); go_fixed(); end
            P_R_TOK:  begin op = OP_TOKEN; wait_left = TOKEN_WAIT; send_byte(8'hFF); end
            P_R_DATA:
            begin
                op = OP_DATA; byte_idx = 0; pn = 0; pword = 0; send_byte(8'hFF);
            end
            P_W_CMD:  begin cs = 1; frame(2, 8'h58, card_addr(), 8'hFF); go_fixed(); end
            P_W_TOK:  begin fbuf[0] = 8'hFF; fbuf[1] = 8'hFE; flen = 2; go_fixed(); end
            P_W_BYTE: begin fbuf[0] = wr_hold; flen = 1; go_fixed(); end
            P_F_PAD:
                if (wleft == 0) go_step(P_F_POLL);
                else go_repeat(8'h00, wleft);
            P_F_BUSY: begin op = OP_BUSY; send_byte(8'hFF); end
            default:  begin op = OP_POLL; poll_left = RESPONSE_POLL; send_byte(8'hFF); end
        endcase
    endfunction

    // cache serve: packed words, last one also closes the request
    function void serve();
        bit [63:0] w;
        bit        last;
        w = 0;
        if (rcnt == 0)
        begin
            done_with(ST_OK);
            return;
        end
        step = P_IDLE;
        for (int i = 0; i < rcnt; i++)
        begin
            w |= 64'(store[(roff + i) % BLOCK_BYTES]) << (8 * (i % 8));
            if ((i % 8) == 7 || i + 1 == rcnt)
            begin
                last = (i + 1 == rcnt);
                put(0, 0, w, (i % 8) + 1, last, last, ST_OK);
                w = 0;
            end
        end
    endfunction

    function void retry_or_fail(step_t p);
        if (retry_left > 1)
        begin
            retry_left--;
            go_step(p);
        end
        else
            done_with(ST_ERR);
    endfunction

    function void advance(bit [7:0] rx);
        case (step)
            P_I_IDLE: begin retry_left = CMD_TRIES; go_step(P_I_C0); end
            P_I_C0P:  begin c0_ok = (rx == 8'h01); go_step(P_I_C0H); end
            P_I_C0H:  if (c0_ok) go_step(P_I_C8); else retry_or_fail(P_I_C0);
            P_I_C8P:  begin hcs = !rx[2]; go_step(P_I_C8T); end
            P_I_C8T:  begin retry_left = OPCOND_TRIES; go_step(P_I_AH); end
            P_I_A41P:
                if (rx == 0) begin retry_left = CMD_TRIES; go_step(P_I_C59); end
                else retry_or_fail(P_I_AH);
            P_I_C59P:
                if (rx == 0) begin retry_left = CMD_TRIES; go_step(P_I_C16); end
                else retry_or_fail(P_I_C59);
            P_I_C16P: if (rx == 0) go_step(P_I_C58); else retry_or_fail(P_I_C16);
            P_I_OCR:  begin am = rx[6] ? AM_BLOCK : AM_BYTE; go_step(P_I_OCRT); end
            P_I_OCRT: go_step(P_I_END);
            P_I_END:  done_with(ST_OK);
            P_R_TOK:
                if (rx == 8'hFE)
                begin
                    if (to_cache) begin csec = rsec; cvalid = 1; end
                    go_step(P_R_DATA);
                end
                else
                    go_step(P_R_ERR);
            P_R_DATA: go_step(P_R_CRC);
            P_R_CRC:  go_step(P_R_END);
            P_R_END:  if (to_cache) serve(); else done_with(ST_OK);
            P_R_ERR:  done_with(ST_ERR);
            P_W_CMDP: if (rx != 0) done_with(ST_ERR); else go_step(P_W_TOK);
            P_W_TOK:  begin wopen = 1; wleft = BLOCK_BYTES; done_with(ST_OK); end
            P_W_BYTE: done_with(ST_OK);
            P_F_PAD:  go_step(P_F_POLL);
            P_F_POLL: go_step(P_F_BUSY);
            P_F_BUSY: begin wopen = 0; wleft = 0; go_step(P_F_END); end
            P_F_END:
                if (fin_init) begin fin_init = 0; go_step(P_I_IDLE); end
                else done_with(ST_OK);
            default:  go_step(step_t'(step + 1));   // frame -> poll, poll -> next
        endcase
    endfunction

    function void card_byte(bit [7:0] rx);
        case (op)
            OP_FIXED:
            begin
                byte_idx++;
                if (byte_idx < flen) send_byte(fbuf[byte_idx]); else advance(rx);
            end
            OP_REPEAT:
                if (rep_left > 1) begin rep_left--; send_byte(rep_byte); end
                else advance(rx);
            OP_POLL:
                if (rx != 8'hFF || poll_left <= 1) advance(rx);
                else begin poll_left--; send_byte(8'hFF); end
            OP_TOKEN:
                if (rx == 8'hFE || wait_left <= 1) advance(rx);
                else begin wait_left--; send_byte(8'hFF); end
            OP_DATA:
            begin
                if (to_cache)
                    store[byte_idx % BLOCK_BYTES] = rx;
                else
                begin
                    pword |= 64'(rx) << (8 * (pn % 8));
                    pn++;
                    if (pn == 8) begin wpend = 1; plast = (byte_idx + 1 == BLOCK_BYTES); end
                end
                byte_idx++;
                if (byte_idx < BLOCK_BYTES) send_byte(8'hFF); else advance(rx);
            end
            default:
                if (rx == 8'hFF) advance(rx); else send_byte(8'hFF);
        endcase
    endfunction

    function void start_read(bit [31:0] sec, int off, int n);
        if (am == AM_NONE) begin done_with(ST_NOTRDY); return; end
        if (wopen) begin done_with(ST_ERR); return; end
        if (n == BLOCK_BYTES) off = 0;
        else if (n > BLOCK_BYTES || off + n > BLOCK_BYTES)
        begin
            done_with(ST_ERR);
            return;
        end
        rsec = sec; roff = off; rcnt = n;
        if (cvalid && csec == sec) begin serve(); return; end
        to_cache = (n != BLOCK_BYTES);
        wpend = 0;
        go_step(P_R_CMD);
    endfunction

    // accepted input word
    function void note_word(item_t it);
        if (it.req_type == REQ_CARD)
        begin
            if (step != P_IDLE) card_byte(it.rx_byte);
            return;
        end
        if (it.req_type > REQ_CARD || step != P_IDLE) return;
        case (it.req_type)
            REQ_INIT:
            begin
                fin_init = wopen;
                go_step(fin_init ? P_F_PAD : P_I_IDLE);
            end
            REQ_READ: start_read(it.sector, it.offset, it.count);
            REQ_WOPEN:
                if (am == AM_NONE) done_with(ST_NOTRDY);
                else if (it.sector == 0)
                begin
                    if (!wopen) done_with(ST_NOTRDY);
                    else begin fin_init = 0; go_step(P_F_PAD); end
                end
                else if (wopen) done_with(ST_ERR);
                else begin rsec = it.sector; go_step(P_W_CMD); end
            REQ_WBYTE:
                if (am == AM_NONE || !wopen) done_with(ST_NOTRDY);
                else if (wleft == 0) done_with(ST_ERR);
                else begin wleft--; wr_hold = it.wr_byte; go_step(P_W_BYTE); end
            default:
                if (am == AM_NONE || !wopen) done_with(ST_NOTRDY);
                else begin fin_init = 0; go_step(P_F_PAD); end
        endcase
    endfunction

    function void flag(string msg);
        bad++;
        if (shown < 10)
        begin
            shown++;
            $display("mismatch: %s", msg);
        end
    endfunction

    function void check_word(res_t got);
        res_t e;
        if (exchange_q.size() == 0)
        begin
            flag($sformatf("unexpected word %h", got));
            return;
        end
        e = exchange_q.pop_front();
        if (got !== e)
            flag($sformatf({"tx %h/%h txv %b/%b cs %b/%b word %h/%h nb %0d/%0d ",
                            "last %b/%b done %b/%b st %0d/%0d (exp/got)"},
                           e.tx_byte, got.tx_byte, e.tx_valid, got.tx_valid,
                           e.cs_active, got.cs_active, e.rd_word, got.rd_word,
                           e.rd_bytes, got.rd_bytes, e.rd_last, got.rd_last,
                           e.done_res, got.done_res, e.status, got.status));
    endfunction

    // what a plausible card answers for the byte now being exchanged
    function bit [7:0] card_reply();
        if (silent) return 8'hFF;
        case (op)
            OP_POLL:
            begin
                if ($urandom_range(0, 2) == 0) return 8'hFF;
                case (step)
                    P_I_C0P:  return 8'h01;
                    P_I_C8P:  return $urandom_range(0, 1) ? 8'h01 : 8'h05;
                    P_I_A55P: return 8'h01;
                    P_I_A41P: return ($urandom_range(0, 2) == 0) ? 8'h01 : 8'h00;
                    P_W_CMDP: return ($urandom_range(0, 7) == 0) ? 8'h05 : 8'h00;
                    P_F_POLL: return 8'h05;
                    default:  return ($urandom_range(0, 9) == 0) ? 8'h01 : 8'h00;
                endcase
            end
            OP_TOKEN:
                if (no_token) return 8'hFF;
                else return ($urandom_range(0, 3) == 0) ? 8'hFE : 8'($urandom_range(0, 253));
            OP_BUSY:  return ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom_range(0, 254));
            OP_DATA:  return 8'($urandom_range(0, 255));
            default:
                if (step == P_I_OCR || $urandom_range(0, 7) == 0)
                    return 8'($urandom_range(0, 255));
                else
                    return 8'hFF;
        endcase
    endfunction
endclass

module tb_sd_spi_sector_controller;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;
    logic        m_tlast;

    spi_seq_tracker trk;
    int src_pct;        // chance in 100 of a sender gap
    int sink_pct;       // chance in 100 of a receiver stall

    sd_spi_sector_controller dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial clk = 0;
    always #4 clk = ~clk;

    // receiver side: random stall when the phase asks for it
    always @(posedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_pct);

    // every accepted output word is checked against the oldest prediction
    always @(posedge clk)
    begin
        res_t r;
        if (rst_n && m_tvalid && m_tready)
        begin
            r.tx_byte   = m_tdata[7:0];
            r.tx_valid  = m_tdata[8];
            r.cs_active = m_tdata[9];
            r.rd_word   = m_tdata[73:10];
            r.rd_bytes  = m_tdata[77:74];
            r.rd_last   = m_tlast;
            r.done_res  = m_tdata[78];
            r.status    = m_tdata[80:79];
            trk.check_word(r);
        end
    end

    function automatic item_t mk(logic [2:0] rq, logic [31:0] sec = 0, logic [8:0] off = 0,
                                 logic [9:0] cnt = 0, logic [7:0] wb = 0, logic [7:0] rx = 0);
        item_t it;
        it.req_type = rq; it.sector = sec; it.offset = off;
        it.count = cnt; it.wr_byte = wb; it.rx_byte = rx;
        return it;
    endfunction

    // one word over the input handshake; sender gaps go in front of it
    task automatic push_item(item_t it);
        if ($urandom_range(0, 99) < src_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, it.rx_byte, it.wr_byte, it.count, it.offset,
                     it.sector, it.req_type};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        trk.note_word(it);
    endtask

    // a host request followed by card bytes until the sequence is idle again;
    // now and then a request arrives mid-sequence and must be dropped
    task automatic run_req(item_t it);
        item_t junk;
        logic [2:0] rq;
        push_item(it);
        while (trk.step != P_IDLE)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                rq = 3'($urandom_range(0, 6));
                if (rq == REQ_CARD) rq = 3'd7;
                junk = mk(rq, $urandom, $urandom, $urandom, $urandom, $urandom);
                push_item(junk);
            end
            push_item(mk(REQ_CARD, $urandom, $urandom, $urandom, $urandom,
                         trk.card_reply()));
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (trk.exchange_q.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_read();
        int         off, cnt;
        logic [31:0] sec;
        sec = trk.cvalid ? trk.csec : $urandom;
        case ($urandom_range(0, 9))
            0:       begin sec = $urandom; off = $urandom_range(0, 511);
                           cnt = $urandom_range(0, 1) ? 512 : $urandom_range(1, 512 - off); end
            1:       begin off = $urandom_range(0, 511); cnt = 512; end
            2:       begin off = $urandom_range(0, 511); cnt = $urandom_range(0, 1023); end
            default: begin off = $urandom_range(0, 511);
                           cnt = $urandom_range(0, (512 - off) < 40 ? 512 - off : 40); end
        endcase
        run_req(mk(REQ_READ, sec, 9'(off), 10'(cnt)));
    endtask

    task automatic write_session();
        int n;
        n = ($urandom_range(0, 14) == 0) ? 513 : $urandom_range(0, 12);
        run_req(mk(REQ_WOPEN, $urandom_range(1, 32'hFFFF_FFFF)));
        for (int i = 0; i < n; i++)
            run_req(mk(REQ_WBYTE, $urandom, $urandom, $urandom, $urandom));
        if ($urandom_range(0, 1)) run_req(mk(REQ_WFIN));
        else run_req(mk(REQ_WOPEN, 0));
    endtask

    task automatic random_phase(int ops);
        int r;
        for (int k = 0; k < ops; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)       run_req(mk(REQ_INIT));
            else if (r < 40) random_read();
            else if (r < 50) run_req(mk(REQ_WOPEN, ($urandom_range(0, 9) == 0) ? 0 : $urandom));
            else if (r < 72) write_session();
            else if (r < 82) run_req(mk(REQ_WBYTE, 0, 0, 0, $urandom));
            else if (r < 88) run_req(mk(REQ_WFIN));
            else if (r < 94) run_req(mk(REQ_CARD, $urandom, $urandom, $urandom, $urandom,
                                        $urandom));
            else             run_req(mk(3'($urandom_range(6, 7)), $urandom, $urandom,
                                        $urandom, $urandom, $urandom));
        end
    endtask

    initial
    begin
        trk      = new();
        src_pct  = 0;
        sink_pct = 0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: nothing ready yet, stray words, unused codes ---
        run_req(mk(REQ_READ, 32'd1, 9'd0, 10'd8));
        run_req(mk(REQ_WOPEN, 32'd5));
        run_req(mk(REQ_WOPEN, 32'd0));
        run_req(mk(REQ_WBYTE, 0, 0, 0, 8'hA5));
        run_req(mk(REQ_WFIN));
        run_req(mk(REQ_CARD, 0, 0, 0, 0, 8'h3C));
        run_req(mk(3'd6, '1, '1, '1, '1, '1));
        run_req(mk(3'd7));

        // card never answers: every CMD0 poll runs out, init gives up
        trk.silent = 1;
        run_req(mk(REQ_INIT));
        trk.silent = 0;
        run_req(mk(REQ_INIT));

        // data token never shows up: bounded wait ends in an error
        trk.no_token = 1;
        run_req(mk(REQ_READ, 32'hFFFF_FFFF, 9'd0, 10'd4));
        trk.no_token = 0;

        // fill the cache, then hit it at the edges of the sector
        run_req(mk(REQ_READ, 32'h1234_5678, 9'd500, 10'd12));
        run_req(mk(REQ_READ, 32'h1234_5678, 9'd0, 10'd0));
        run_req(mk(REQ_READ, 32'h1234_5678, 9'd511, 10'd1));
        run_req(mk(REQ_READ, 32'h1234_5678, 9'd0, 10'd64));
        run_req(mk(REQ_READ, 32'h1234_5678, 9'd511, 10'd2));
        run_req(mk(REQ_READ, 32'h1234_5678, 9'd3, 10'd1023));
        run_req(mk(REQ_READ, 32'h1234_5678, 9'd7, 10'd512));

        // write path: open, bytes, double open, read while open, init closes it
        run_req(mk(REQ_WOPEN, 32'h8000_0001));
        run_req(mk(REQ_WBYTE, 0, 0, 0, 8'h00));
        run_req(mk(REQ_WBYTE, 0, 0, 0, 8'hFF));
        run_req(mk(REQ_WOPEN, 32'h0000_0002));
        run_req(mk(REQ_READ, 32'h1234_5678, 9'd0, 10'd8));
        run_req(mk(REQ_INIT));

        // --- random phases with different stall mixes ---
        random_phase(60);
        drain();                    // sender holds off until all words are in
        src_pct = 70; sink_pct = 0;
        random_phase(50);
        drain();
        src_pct = 0; sink_pct = 70;
        random_phase(50);
        drain();
        src_pct = 29; sink_pct = 29;
        random_phase(50);
        drain();
        src_pct = 0; sink_pct = 0;
        random_phase(20);
        drain();

        if (trk.bad == 0 && trk.exchange_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
